// ===== rtl/awo_pkg.sv =====
`default_nettype none

package awo_pkg;

  // Field and register widths
  localparam int PHASE_STEP_W = 32;
  localparam int GAIN_W       = 15;
  localparam int NOTE_W       = 24;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int SAMPLE_W     = 16;
  localparam int MAG_W        = 15;
  localparam int WEIGHT_W     = 17;
  localparam int WEIGHT_DEPTH = 16;
  localparam int FRAC_SHIFT   = 31;

  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  // Register values after reset
  localparam logic [PHASE_STEP_W-1:0] PHASE_STEP_RST   = 32'd42949673;
  localparam logic                    WAVEFORM_RST     = 1'b0;
  localparam logic [GAIN_W-1:0]       GAIN_RST         = 15'd5000;
  localparam logic [NOTE_W-1:0]       NOTE_SAMPLES_RST = 24'd132300;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PHASE_STEP   = 2'd0,
    CFG_WAVEFORM     = 2'd1,
    CFG_GAIN         = 2'd2,
    CFG_NOTE_SAMPLES = 2'd3
  } awo_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_RUN    = 2'd1,
    ST_DRAIN  = 2'd2,
    ST_FINISH = 2'd3
  } awo_state_e;

  // Q16 weight of odd harmonic k = 2*i+1: (65536 + k/2) / k, integer division
  localparam logic [WEIGHT_W-1:0] WEIGHT [WEIGHT_DEPTH] = '{
    17'd65536, 17'd21845, 17'd13107, 17'd9362,
    17'd7282,  17'd5958,  17'd5041,  17'd4369,
    17'd3855,  17'd3449,  17'd3121,  17'd2849,
    17'd2621,  17'd2427,  17'd2260,  17'd2114
  };

  // pi/2 in Q30 and the Taylor term divisors (2j)(2j+1)
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  // Quarter-wave sine entry m (0 .. 2^(addr_bits-2)) scaled to 32767.
  // Only evaluated at elaboration to fill the ROM.
  function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned m,
                                                    input int unsigned addr_bits);
    logic [63:0] t;
    logic [63:0] th;
    logic [63:0] th2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] amp;
    int          j;
    t    = (64'(m) << 30) >> (addr_bits - 2);
    th   = (t * HALF_PI_Q30) >> 30;
    th2  = (th * th) >> 30;
    term = th;
    sum  = th;
    for (j = 1; j <= 8; j++) begin
      term = ((term * th2) >> 30) / TAYLOR_DIV[j-1];
      if ((j % 2) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    amp = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (amp > 64'd32767) begin
      amp = 64'd32767;
    end
    return amp[MAG_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/awo_sine_rom.sv =====
`default_nettype none

// Quarter-wave sine ROM: fold the full-cycle address into the first quadrant,
// read the magnitude and register it along with the sign.
module awo_sine_rom #(
  parameter int TABLE_ADDR_BITS = 10
) (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [TABLE_ADDR_BITS-1:0] addr_i,
  output logic      [awo_pkg::MAG_W-1:0]  mag_o,
  output logic                            neg_o
);

  localparam int QUARTER = 2 ** (TABLE_ADDR_BITS - 2);
  localparam int IDX_W   = TABLE_ADDR_BITS - 1;

  logic [awo_pkg::MAG_W-1:0]  rom [QUARTER+1];
  logic [TABLE_ADDR_BITS-3:0] rem;
  logic [IDX_W-1:0]           idx;
  logic [awo_pkg::MAG_W-1:0]  mag_q;
  logic                       neg_q;

  for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
    assign rom[g] = awo_pkg::quarter_sine(g, TABLE_ADDR_BITS);
  end

  // second and fourth quadrants run the table backwards
  assign rem = addr_i[TABLE_ADDR_BITS-3:0];
  assign idx = addr_i[TABLE_ADDR_BITS-2] ? (IDX_W'(QUARTER) - {1'b0, rem}) : {1'b0, rem};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= rom[idx];
      neg_q <= addr_i[TABLE_ADDR_BITS-1];
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

`default_nettype wire

// ===== rtl/additive_waveform_oscillator.sv =====
`default_nettype none

// Channel   | Dir | Handshake                      | Payload
// ----------+-----+--------------------------------+----------------------------------
// cfg       | in  | cfg_valid_i / cfg_ready_o      | cfg_addr_i (register), cfg_data_i
// s_axis    | in  | s_axis_tvalid / s_axis_tready  | tdata[0] start_req
// m_axis    | out | m_axis_tvalid / m_axis_tready  | tdata sample, tlast note_last,
//           |     |                                | tuser[0] note_active
//
// One input beat is one sample tick. A playing tick issues H harmonics, with
// H = 1 in sine mode and H = HARMONIC_COUNT in square mode, one per cycle
// through the shared phase adder, sine ROM and two-stage multiplier; then the
// pipe drains and the sum is scaled and saturated into the output register.
// A tick with no note playing skips straight to the output step.
// Reset (rst_ni low, asynchronous) restores the register defaults, stops the
// note and empties the output register. A stalled output beat holds; the
// next input beat is taken meanwhile and its result waits in the scale step.
module additive_waveform_oscillator #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int COUNT_BITS      = 24,
  parameter int HARMONIC_COUNT  = 6
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration writes
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [awo_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  wire logic [awo_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // sample ticks
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [7:0]                          s_axis_tdata,  // [0] start_req
  // samples
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic      [awo_pkg::SAMPLE_W-1:0]        m_axis_tdata,  // [15:0] sample
  output logic                                     m_axis_tlast,  // note_last
  output logic      [0:0]                          m_axis_tuser   // [0] note_active
);

  localparam int HW      = (HARMONIC_COUNT > 1) ? $clog2(HARMONIC_COUNT) : 1;
  localparam int LEN_W   = ((COUNT_BITS > awo_pkg::NOTE_W) ? COUNT_BITS : awo_pkg::NOTE_W) + 1;
  localparam int P1_W    = awo_pkg::GAIN_W + awo_pkg::MAG_W;
  localparam int P2_W    = P1_W + awo_pkg::WEIGHT_W;
  localparam int ACC_W   = P2_W + $clog2(HARMONIC_COUNT + 1) + 1;
  localparam int OUT_W   = ACC_W - awo_pkg::FRAC_SHIFT;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [awo_pkg::PHASE_STEP_W-1:0] phase_step_q;
  logic                             waveform_q;
  logic [awo_pkg::GAIN_W-1:0]       gain_q;
  logic [awo_pkg::NOTE_W-1:0]       note_samples_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q   <= awo_pkg::PHASE_STEP_RST;
      waveform_q     <= awo_pkg::WAVEFORM_RST;
      gain_q         <= awo_pkg::GAIN_RST;
      note_samples_q <= awo_pkg::NOTE_SAMPLES_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (awo_pkg::awo_cfg_e'(cfg_addr_i))
        awo_pkg::CFG_PHASE_STEP:   phase_step_q   <= cfg_data_i[awo_pkg::PHASE_STEP_W-1:0];
        awo_pkg::CFG_WAVEFORM:     waveform_q     <= cfg_data_i[0];
        awo_pkg::CFG_GAIN:         gain_q         <= cfg_data_i[awo_pkg::GAIN_W-1:0];
        awo_pkg::CFG_NOTE_SAMPLES: note_samples_q <= cfg_data_i[awo_pkg::NOTE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  awo_pkg::awo_state_e state_q, state_d;

  logic                  in_beat;
  logic                  start_req;
  logic                  issue;
  logic                  last_issue;
  logic                  finish_load;
  logic                  out_free;
  logic                  pipe_busy;

  logic [PHASE_BITS-1:0] phase_q;     // note phase
  logic [PHASE_BITS-1:0] ph_q;        // harmonic phase, k * phase
  logic [COUNT_BITS-1:0] cnt_q;
  logic                  playing_q;
  logic                  silent_q;
  logic [HW-1:0]         hcnt_q;

  logic                  vld_a_q, vld_b_q, vld_c_q;

  assign start_req = s_axis_tdata[0];
  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign pipe_busy = vld_a_q || vld_b_q || vld_c_q;
  assign last_issue = waveform_q ? (hcnt_q == HW'(HARMONIC_COUNT - 1)) : 1'b1;

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    finish_load   = 1'b0;
    case (state_q)
      awo_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          // a tick with no note playing skips straight to the output step
          state_d = (start_req || playing_q) ? awo_pkg::ST_RUN : awo_pkg::ST_FINISH;
        end
      end
      awo_pkg::ST_RUN: begin
        issue = 1'b1;
        if (last_issue) begin
          state_d = awo_pkg::ST_DRAIN;
        end
      end
      awo_pkg::ST_DRAIN: begin
        if (!pipe_busy) begin
          state_d = awo_pkg::ST_FINISH;
        end
      end
      awo_pkg::ST_FINISH: begin
        if (out_free) begin
          finish_load = 1'b1;
          state_d     = awo_pkg::ST_IDLE;
        end
      end
      default: state_d = awo_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= awo_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared phase adder: step the harmonic phase by 2*phase while issuing,
  // advance the note phase by the aligned step when finishing.
  // ---------------------------------------------------------------------------
  logic [PHASE_BITS+31:0] step_wide;
  logic [PHASE_BITS-1:0]  step_al;
  logic [PHASE_BITS-1:0]  add_a, add_b, add_sum;
  logic                   fin_sel;

  assign step_wide = {phase_step_q, PHASE_BITS'(0)};
  assign step_al   = step_wide[PHASE_BITS+31:32];
  assign fin_sel   = (state_q == awo_pkg::ST_FINISH);
  assign add_a     = fin_sel ? phase_q : ph_q;
  assign add_b     = fin_sel ? step_al : {phase_q[PHASE_BITS-2:0], 1'b0};
  assign add_sum   = add_a + add_b;

  // note length: zero counts as one, clamp to what the counter can reach
  logic [LEN_W-1:0] len_raw, len, cnt_inc;
  logic             note_last;

  assign len_raw   = LEN_W'(note_samples_q);
  always_comb begin
    len = len_raw;
    if (len_raw == '0) begin
      len = LEN_W'(1);
    end
    if (len_raw > LEN_W'({COUNT_BITS{1'b1}})) begin
      len = LEN_W'({COUNT_BITS{1'b1}});
    end
  end
  assign cnt_inc   = LEN_W'(cnt_q) + LEN_W'(1);
  assign note_last = (cnt_inc >= len);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      cnt_q     <= '0;
      playing_q <= 1'b0;
      silent_q  <= 1'b1;
      hcnt_q    <= '0;
    end else begin
      if (in_beat) begin
        silent_q <= !(start_req || playing_q);
        hcnt_q   <= '0;
        if (start_req) begin
          phase_q   <= '0;
          cnt_q     <= '0;
          playing_q <= 1'b1;
        end
      end
      if (issue) begin
        hcnt_q <= hcnt_q + HW'(1);
      end
      if (finish_load && !silent_q) begin
        phase_q <= add_sum;
        if (note_last) begin
          cnt_q     <= '0;
          playing_q <= 1'b0;
        end else begin
          cnt_q <= cnt_inc[COUNT_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      ph_q <= start_req ? '0 : phase_q;
    end else if (issue) begin
      ph_q <= add_sum;
    end
  end

  // ---------------------------------------------------------------------------
  // Harmonic pipe: ROM read, gain multiply, weight multiply, accumulate
  // ---------------------------------------------------------------------------
  logic [awo_pkg::MAG_W-1:0] mag;
  logic                      neg_a;
  logic [HW-1:0]             hidx_a_q, hidx_b_q;
  logic                      neg_b_q, neg_c_q;
  logic [P1_W-1:0]           p1_q;
  logic [P2_W-1:0]           p2_q;
  logic signed [ACC_W-1:0]   acc_q;

  awo_sine_rom #(
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
  ) u_awo_sine_rom (
    .clk_i (clk_i),
    .en_i  (issue),
    .addr_i(ph_q[PHASE_BITS-1 -: TABLE_ADDR_BITS]),
    .mag_o (mag),
    .neg_o (neg_a)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else begin
      vld_a_q <= issue;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hidx_a_q <= hcnt_q;
    hidx_b_q <= hidx_a_q;
    neg_b_q  <= neg_a;
    neg_c_q  <= neg_b_q;
    p1_q     <= P1_W'(gain_q) * P1_W'(mag);
    p2_q     <= P2_W'(p1_q) * P2_W'(awo_pkg::WEIGHT[4'(hidx_b_q)]);
    if (in_beat) begin
      acc_q <= '0;
    end else if (vld_c_q) begin
      acc_q <= neg_c_q ? (acc_q - $signed(ACC_W'(p2_q))) : (acc_q + $signed(ACC_W'(p2_q)));
    end
  end

  // ---------------------------------------------------------------------------
  // Scale by 2^-31 toward zero, saturate, load the output register
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0]          biased;
  logic signed [OUT_W-1:0]          scaled;
  logic        [awo_pkg::SAMPLE_W-1:0] sample_d;

  assign biased = acc_q + (acc_q[ACC_W-1] ? $signed(ACC_W'((64'd1 << awo_pkg::FRAC_SHIFT) - 64'd1))
                                          : $signed(ACC_W'(0)));
  assign scaled = biased[ACC_W-1:awo_pkg::FRAC_SHIFT];

  always_comb begin
    sample_d = scaled[awo_pkg::SAMPLE_W-1:0];
    if (scaled > $signed(OUT_W'(awo_pkg::SAMPLE_MAX))) begin
      sample_d = awo_pkg::SAMPLE_W'(awo_pkg::SAMPLE_MAX);
    end else if (scaled < $signed(OUT_W'(awo_pkg::SAMPLE_MIN))) begin
      sample_d = awo_pkg::SAMPLE_W'(awo_pkg::SAMPLE_MIN);
    end
  end

  logic                           out_valid_q;
  logic [awo_pkg::SAMPLE_W-1:0]   out_sample_q;
  logic                           out_last_q;
  logic                           out_active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish_load) begin
      out_sample_q <= sample_d;
      out_last_q   <= note_last && !silent_q;
      out_active_q <= !silent_q;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_sample_q;
  assign m_axis_tlast    = out_last_q;
  assign m_axis_tuser[0] = out_active_q;

endmodule

`default_nettype wire

// ===== rtl/awo_checker.sv =====
`default_nettype none

module awo_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic [0:0]  m_axis_tuser
);

  // a stalled output beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // the closing sample of a note belongs to a note
  a_last_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
    else $error("note_last without note_active");

  // idle ticks are silent
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata == 16'd0))
    else $error("nonzero sample outside a note");

  // one tick at a time: ready drops right after a beat is taken
  a_one_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready held across a tick");

endmodule

bind additive_waveform_oscillator awo_checker u_awo_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire

// ===== tb/sv/tb_additive_waveform_oscillator.sv =====
`timescale 1ns / 1ps

module tb_additive_waveform_oscillator;
  import awo_pkg::*;

  // Block geometry, matching the defaults the block is built with
  localparam int ROM_BITS      = 10;
  localparam int ROM_DEPTH     = 1 << ROM_BITS;
  localparam int HARMONICS     = 6;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASES        = 12;
  localparam int TICKS_PER_PH  = 100;
  localparam logic [63:0] HALF_PI_FIX = 64'd1686629713;  // pi/2 in Q30

  // Sink ready patterns
  localparam int SINK_ALWAYS = 0;
  localparam int SINK_RANDOM = 1;
  localparam int SINK_CYCLIC = 2;
  localparam int SINK_SPARSE = 3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       active;
  } tone_beat_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_valid_i   = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_ADDR_W-1:0]   cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i    = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [7:0]              s_axis_tdata  = '0;  // [0] start_req
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [SAMPLE_W-1:0]     m_axis_tdata;        // [15:0] sample
  logic                    m_axis_tlast;        // note_last
  logic [0:0]              m_axis_tuser;        // [0] note_active

  // Oscillator state as the testbench sees it
  logic [31:0]             reg_step;
  logic                    reg_wave;
  logic [GAIN_W-1:0]       reg_gain;
  logic [NOTE_W-1:0]       reg_len;
  logic [31:0]             tone_phase;
  logic [NOTE_W-1:0]       tone_count;
  logic                    tone_on;
  int                      sine_rom [ROM_DEPTH];

  tone_beat_t              pending_samples [$];
  int                      mismatch_count = 0;

  // Sink control, written by the tests and followed by the sink process
  int                      sink_mode   = SINK_ALWAYS;
  int                      hold_len    = 0;
  int                      hold_token  = 0;
  int                      hold_seen   = 0;
  int                      hold_cnt    = 0;
  logic [7:0]              stall_phase = '0;

  always #5 clk_i = ~clk_i;

  additive_waveform_oscillator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // ---------------------------------------------------------------------------
  // Sine ROM contents: quarter wave from a Q30 Taylor series, mirrored out to
  // the full cycle. Every product is truncated back to Q30 before the next.
  // ---------------------------------------------------------------------------
  function automatic int taylor_quarter(input int unsigned m);
    logic [63:0] x;
    logic [63:0] th;
    logic [63:0] th2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] amp;
    x    = (64'(m) << 30) >> (ROM_BITS - 2);
    th   = (x * HALF_PI_FIX) >> 30;
    th2  = (th * th) >> 30;
    term = th;
    sum  = th;
    for (int j = 1; j <= 8; j++) begin
      term = ((term * th2) >> 30) / 64'((2 * j) * (2 * j + 1));
      // odd terms subtract, floored at zero
      if (j % 2 == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    amp = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (amp > 64'd32767) begin
      amp = 64'd32767;
    end
    return int'(amp);
  endfunction

  function automatic void fill_sine_rom();
    int quad;
    int offs;
    int mag;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      quad = i >> (ROM_BITS - 2);
      offs = i & (ROM_DEPTH / 4 - 1);
      mag  = taylor_quarter((quad % 2 == 1) ? ROM_DEPTH / 4 - offs : offs);
      sine_rom[i] = (quad >= 2) ? -mag : mag;
    end
  endfunction

  // Weighted sum of the active harmonics at the current phase, scaled down by
  // 2^31 with truncation toward zero and clamped to the sample range.
  function automatic logic signed [SAMPLE_W-1:0] mix_harmonics();
    longint      acc;
    longint      weight;
    logic [31:0] k;
    logic [31:0] ph;
    int          addr;
    int          nharm;
    nharm = reg_wave ? HARMONICS : 1;
    acc   = 0;
    for (int h = 0; h < nharm; h++) begin
      k      = 32'(2 * h + 1);
      ph     = tone_phase * k;
      addr   = int'(ph >> (32 - ROM_BITS));
      weight = (longint'(65536) + longint'(k / 2)) / longint'(k);
      acc    = acc + longint'(reg_gain) * longint'(sine_rom[addr]) * weight;
    end
    acc = acc / (longint'(1) <<< 31);
    if (acc > SAMPLE_MAX) begin
      acc = SAMPLE_MAX;
    end
    if (acc < SAMPLE_MIN) begin
      acc = SAMPLE_MIN;
    end
    return acc[SAMPLE_W-1:0];
  endfunction

  // Advance the oscillator by one accepted tick and return the sample it gives.
  function automatic tone_beat_t advance_tick(input logic start);
    tone_beat_t  beat;
    logic [31:0] len;
    beat = '0;
    if (start) begin
      tone_phase = '0;
      tone_count = '0;
      tone_on    = 1'b1;
    end
    if (!tone_on) begin
      return beat;
    end
    // zero length plays a single sample
    len = (reg_len == '0) ? 32'd1 : 32'(reg_len);
    beat.sample = mix_harmonics();
    beat.last   = (32'(tone_count) + 32'd1 >= len);
    beat.active = 1'b1;
    tone_count  = tone_count + 1'b1;
    tone_phase  = tone_phase + reg_step;
    if (beat.last) begin
      tone_on    = 1'b0;
      tone_count = '0;
    end
    return beat;
  endfunction

  // ---------------------------------------------------------------------------
  // Sink: stalls on its own pattern, or holds off for a requested stretch.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1'b1;
    if (hold_seen != hold_token) begin
      hold_seen     <= hold_token;
      hold_cnt      <= hold_len;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt      <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      case (sink_mode)
        SINK_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
        SINK_CYCLIC: m_axis_tready <= ((stall_phase % 7) > 2);
        SINK_SPARSE: m_axis_tready <= ($urandom_range(0, 4) == 0);
        default:     m_axis_tready <= 1'b1;
      endcase
    end
  end

  // Check every output beat against the oldest predicted sample.
  always @(posedge clk_i) begin
    tone_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected output beat: sample %0d", $signed(m_axis_tdata));
        mismatch_count++;
      end else begin
        want = pending_samples.pop_front();
        if (m_axis_tdata !== want.sample) begin
          $error("sample: expected %0d, got %0d", want.sample, $signed(m_axis_tdata));
          mismatch_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("note_last: expected %0d, got %0d", want.last, m_axis_tlast);
          mismatch_count++;
        end
        if (m_axis_tuser[0] !== want.active) begin
          $error("note_active: expected %0d, got %0d", want.active, m_axis_tuser[0]);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one tick beat and hold it until accepted; predict on acceptance.
  task automatic send_tick(input logic start);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, start};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_samples.push_back(advance_tick(start));
  endtask

  // Drop valid for a gap whose length is n; a zero gap leaves valid alone.
  task automatic pause_ticks(input int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Stop offering ticks and wait until every predicted sample has come out.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_samples.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write beat; only called with the block idle.
  task automatic write_reg(input awo_cfg_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_PHASE_STEP:   reg_step = value;
      CFG_WAVEFORM:     reg_wave = value[0];
      CFG_GAIN:         reg_gain = value[GAIN_W-1:0];
      CFG_NOTE_SAMPLES: reg_len  = value[NOTE_W-1:0];
      default:          ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(input logic [31:0] step, input logic wave,
                           input logic [GAIN_W-1:0] gain, input logic [NOTE_W-1:0] len);
    settle();
    write_reg(CFG_PHASE_STEP, step);
    write_reg(CFG_WAVEFORM, 32'(wave));
    write_reg(CFG_GAIN, 32'(gain));
    write_reg(CFG_NOTE_SAMPLES, 32'(len));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Idle ticks give silence; a start with reset defaults plays a sine note.
  task automatic test_idle_and_defaults();
    sink_mode <= SINK_ALWAYS;
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  // Register extremes, short and zero-length notes, restart mid-note, and a
  // register change while a note is still sounding.
  task automatic test_register_extremes();
    sink_mode <= SINK_RANDOM;
    write_all(32'd0, 1'b0, 15'd0, 24'd3);
    repeat (3) send_tick(1'b0);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);

    write_all(32'hFFFF_FFFF, 1'b1, 15'h7FFF, 24'd1);
    send_tick(1'b1);
    send_tick(1'b0);

    write_all(32'hFFFF_FFFF, 1'b1, 15'h7FFF, 24'd0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);

    write_all(32'h0800_0000, 1'b0, 15'h7FFF, 24'd2);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);

    // quarter-cycle steps land on the waveform's peaks and zero crossings
    write_all(32'h4000_0000, 1'b1, 15'h7FFF, 24'hFF_FFFF);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    settle();
    write_reg(CFG_GAIN, 32'd1234);
    write_reg(CFG_WAVEFORM, 32'd0);
    repeat (2) send_tick(1'b0);
  endtask

  // Hold the sink off for a long stretch while ticks keep coming, so the block
  // backs up and stalls its input; then pause until everything has drained.
  task automatic test_output_holdoff();
    write_all(32'h0123_4567, 1'b1, 15'd20000, 24'd50);
    sink_mode  <= SINK_ALWAYS;
    hold_len   <= 400;
    hold_token <= hold_token + 1;
    send_tick(1'b1);
    repeat (29) send_tick(1'b0);
    settle();
  endtask

  // Random phases of notes: mostly well-formed notes with random content,
  // plus idle ticks and restarts mid-note.
  task automatic test_random_notes();
    logic [31:0]       step;
    logic [GAIN_W-1:0] gain;
    logic [NOTE_W-1:0] len;
    logic              start;
    int                burst_left;
    bit                quiet;
    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0:       step = $urandom();
        1:       step = $urandom_range(1, 32'h0100_0000);
        2:       step = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h8000_0000;
        default: step = $urandom_range(0, 32'h0FFF_FFFF);
      endcase
      case ($urandom_range(0, 4))
        0:       gain = 15'h7FFF;
        1:       gain = $urandom_range(0, 15);
        default: gain = $urandom_range(0, 32767);
      endcase
      case ($urandom_range(0, 9))
        0:       len = '0;
        1:       len = 24'hFF_FFFF;
        2:       len = $urandom_range(1, 24'hFF_FFFF);
        default: len = $urandom_range(1, 40);
      endcase
      write_all(step, 1'($urandom_range(0, 1)), gain, len);

      // some phases run with no idling on either side
      quiet = ($urandom_range(0, 3) == 0);
      sink_mode <= quiet ? SINK_ALWAYS : $urandom_range(SINK_RANDOM, SINK_SPARSE);
      burst_left = 0;
      for (int n = 0; n < TICKS_PER_PH; n++) begin
        if (tone_on) begin
          start = ($urandom_range(0, 29) == 0);
        end else begin
          start = ($urandom_range(0, 3) != 0);
        end
        send_tick(start);
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          if (!quiet && $urandom_range(0, 1) == 1) begin
            pause_ticks($urandom_range(1, 12));
          end
        end else begin
          burst_left--;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    fill_sine_rom();
    reg_step   = PHASE_STEP_RST;
    reg_wave   = WAVEFORM_RST;
    reg_gain   = GAIN_RST;
    reg_len    = NOTE_SAMPLES_RST;
    tone_phase = '0;
    tone_count = '0;
    tone_on    = 1'b0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_and_defaults();
    test_register_extremes();
    test_output_holdoff();
    test_random_notes();
    settle();

    if (mismatch_count == 0) begin
      $display("tb_additive_waveform_oscillator: clean");
    end else begin
      $display("tb_additive_waveform_oscillator: errors");
    end
    $finish;
  end

  // Generous cap on the whole run
  initial begin
    #5ms;
    $display("tb_additive_waveform_oscillator: errors");
    $finish;
  end

endmodule
